// File: src/reed_solomon_systematic_encoder_unit_defines.svh
// Assertion macros shared by the Reed-Solomon encoder RTL.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef REED_SOLOMON_SYSTEMATIC_ENCODER_UNIT_DEFINES_SVH
`define REED_SOLOMON_SYSTEMATIC_ENCODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSSE_ASSERT_HOLDS(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSSE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rsse_pkg.sv
// Package of the Reed-Solomon encoder: widths, shared types and GF(2^m) arithmetic.
// Depends on nothing; every module of the encoder imports it.
package rsse_pkg;

    localparam int SYMBOL_BITS = 8;
    localparam int MAX_PARITY  = 16;

    localparam int PAR_W   = $clog2(MAX_PARITY + 1);
    localparam int IDX_W   = $clog2(MAX_PARITY);
    localparam int MSG_W   = 8;
    localparam int DATA_W  = ((MSG_W + 7) / 8) * 8;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LEN  = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_FIELD_POLY   = 8'd29;
    localparam logic [4:0]       RST_PARITY_COUNT = 5'd16;
    localparam logic [CFG_W-1:0] RST_MESSAGE_LEN  = 8'd239;

    typedef logic [SYMBOL_BITS-1:0] t_sym;
    typedef logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] t_sym_arr;

    // Field and code size in force for the generator now held.
    typedef struct packed {
        t_sym             poly;
        logic [PAR_W-1:0] par;
    } t_gen_cfg;

    typedef struct packed {
        logic valid;
        logic busy;
    } t_gen_status;

    // One classified message symbol waiting for the LFSR.
    typedef struct packed {
        logic last;
        t_sym sym;
    } t_qent;

    // Multiply by alpha (the element x) modulo the field polynomial.
    function automatic t_sym gf_xtime(t_sym x, t_sym poly);
        t_sym shifted;
        shifted = {x[SYMBOL_BITS-2:0], 1'b0};
        return x[SYMBOL_BITS-1] ? (shifted ^ poly) : shifted;
    endfunction

    // Shift-and-add GF(2^m) product, one bit of b per step.
    function automatic t_sym gf_mul(t_sym a, t_sym b, t_sym poly);
        t_sym acc;
        t_sym x;
        acc = '0;
        x   = a;
        for (int i = 0; i < SYMBOL_BITS; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x, poly);
        end
        return acc;
    endfunction

endpackage

// File: src/reed_solomon_systematic_encoder_unit.sv
// Top level of the systematic Reed-Solomon encoder over GF(2^m).
// Depends on rsse_pkg, rsse_front, rsse_fifo, rsse_gen, rsse_back and the defines header.
//
//  Channel   | Direction | Payload
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | tdata[7:0] msg_symbol
//  m_axis    | out       | tdata[7:0] code_symbol, tuser is_parity,
//            |           | tlast end_of_codeword
//  cfg       | in        | we, idx (0 field poly, 1 parity count, 2 length), data
//
// Each message symbol is taken in and echoed, one request per cycle when neither side stalls.
// The last symbol of a codeword is followed by P parity requests, one a cycle
// while the output is not held, read straight out of the LFSR, so a codeword
// of k symbols gives k+P output symbols. After reset or a write to the field
// polynomial or parity count, the first codeword waits for the previous one to
// drain, for the settings to be latched and for the generator build (P the
// clamped parity count), one root multiplied in a cycle.
// Reset is synchronous and active low; either side may stall at any time, the
// two-entry queue and the output register keep the front and back apart.
`include "reed_solomon_systematic_encoder_unit_defines.svh"

module reed_solomon_systematic_encoder_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave side, tdata: msg_symbol [7:0]
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [rsse_pkg::MSG_W-1:0]       i_s_axis_tdata,
    // Master side, tdata: code_symbol [7:0]; tuser: is_parity; tlast: end_of_codeword
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [rsse_pkg::DATA_W-1:0]      o_m_axis_tdata,
    output logic                             o_m_axis_tuser,
    output logic                             o_m_axis_tlast,
    // Configuration writes
    input  logic                             i_cfg_we,
    input  logic [rsse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rsse_pkg::CFG_W-1:0]       i_cfg_data
);
    import rsse_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]   r_cfg_poly;
    logic [4:0]         r_cfg_parity;
    logic [COUNT_W-1:0] r_cfg_len;
    logic               w_cfg_touch;

    // Front to queue.
    logic        w_push;
    t_qent       w_entry;
    logic        w_front_at_start;

    // Queue to back.
    t_qent       w_head;
    logic        w_q_empty;
    logic        w_q_full;
    logic        w_pop;
    logic        w_back_idle;

    // Generator.
    t_sym_arr    w_coeffs;
    t_gen_cfg    w_act;
    t_gen_status w_gen_stat;
    logic        w_start_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_poly   <= RST_FIELD_POLY;
            r_cfg_parity <= RST_PARITY_COUNT;
            r_cfg_len    <= RST_MESSAGE_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIELD_POLY: begin
                    r_cfg_poly <= i_cfg_data;
                end
                CFG_PARITY_COUNT: begin
                    r_cfg_parity <= i_cfg_data[4:0];
                end
                CFG_MESSAGE_LEN: begin
                    r_cfg_len <= i_cfg_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Any write to the field or the parity count makes the held generator stale.
    assign w_cfg_touch = i_cfg_we &&
                         ((i_cfg_idx == CFG_FIELD_POLY) || (i_cfg_idx == CFG_PARITY_COUNT));

    // The generator may only be rebuilt between codewords, once nothing of the
    // previous codeword is left in the queue or the LFSR.
    assign w_start_ok = w_front_at_start && w_q_empty && w_back_idle;

    rsse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_msg_len   (r_cfg_len),
        .i_gen_valid (w_gen_stat.valid),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_entry     (w_entry),
        .o_at_start  (w_front_at_start)
    );

    rsse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    rsse_gen u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_poly   (r_cfg_poly[SYMBOL_BITS-1:0]),
        .i_cfg_parity (r_cfg_parity),
        .i_cfg_touch  (w_cfg_touch),
        .i_start_ok   (w_start_ok),
        .o_coeffs     (w_coeffs),
        .o_act        (w_act),
        .o_status     (w_gen_stat)
    );

    rsse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!w_q_empty),
        .i_entry   (w_head),
        .o_pop     (w_pop),
        .i_coeffs  (w_coeffs),
        .i_act     (w_act),
        .o_idle    (w_back_idle),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_user    (o_m_axis_tuser),
        .o_last    (o_m_axis_tlast)
    );

    `RSSE_ASSERT_HOLDS(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_full, "request pushed into a full queue")
    `RSSE_ASSERT_HOLDS(a_build_drained, i_clk, i_rst_n, w_gen_stat.busy, w_back_idle && w_q_empty && !w_push, "generator rebuilt while a codeword is in flight")
    `RSSE_ASSERT_HOLDS(a_last_is_parity, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser, "codeword end marked on a message echo")

endmodule

// File: src/rsse_fifo.sv
// Two-entry queue of classified symbols between the encoder front and back.
// Depends on rsse_pkg.
module rsse_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsse_pkg::t_qent i_entry,
    input  logic          i_pop,
    output rsse_pkg::t_qent o_head,
    output logic          o_empty,
    output logic          o_full
);
    import rsse_pkg::*;

    t_qent               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// File: src/rsse_front.sv
// Input side of the encoder: takes message symbols, counts them and marks the
// last one of each codeword. Depends on rsse_pkg.
module rsse_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rsse_pkg::MSG_W-1:0]   i_data,
    input  logic [rsse_pkg::COUNT_W-1:0] i_msg_len,
    input  logic                         i_gen_valid,
    input  logic                         i_q_full,
    output logic                         o_push,
    output rsse_pkg::t_qent              o_entry,
    output logic                         o_at_start
);
    import rsse_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] w_k;
    logic [COUNT_W:0]   w_next;
    logic               w_last;

    // A zero length acts as one; a count that wraps past the top also ends it.
    assign w_k    = (i_msg_len == '0) ? COUNT_W'(1) : i_msg_len;
    assign w_next = {1'b0, r_count} + (COUNT_W + 1)'(1);
    assign w_last = (w_next >= {1'b0, w_k}) || w_next[COUNT_W];

    assign o_at_start = (r_count == '0);
    // A new codeword waits for a generator built from the present registers.
    assign o_ready    = !(o_at_start && !i_gen_valid) && !i_q_full;
    assign o_push     = i_valid && o_ready;
    assign o_entry.sym  = i_data[SYMBOL_BITS-1:0];
    assign o_entry.last = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= w_last ? '0 : w_next[COUNT_W-1:0];
        end
    end

endmodule

// File: src/rsse_gen.sv
// Generator builder: multiplies out (X+alpha^1)...(X+alpha^P), one root a cycle.
// Depends on rsse_pkg.
module rsse_gen (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rsse_pkg::t_sym        i_cfg_poly,
    input  logic [4:0]            i_cfg_parity,
    input  logic                  i_cfg_touch,
    input  logic                  i_start_ok,
    output rsse_pkg::t_sym_arr    o_coeffs,
    output rsse_pkg::t_gen_cfg    o_act,
    output rsse_pkg::t_gen_status o_status
);
    import rsse_pkg::*;

    logic             r_valid;
    logic             r_busy;
    logic [PAR_W-1:0] r_step;
    t_gen_cfg         r_act;
    t_sym             r_root;
    t_sym_arr         r_g;
    t_sym_arr         w_g_next;
    logic [PAR_W-1:0] w_par_clamped;
    logic             w_start;
    logic             w_done;

    // Parity counts outside 2..MAX_PARITY are pulled to the nearest bound.
    always_comb begin
        if (i_cfg_parity < 5'd2) begin
            w_par_clamped = PAR_W'(2);
        end else if (i_cfg_parity > MAX_PARITY) begin
            w_par_clamped = PAR_W'(MAX_PARITY);
        end else begin
            w_par_clamped = PAR_W'(i_cfg_parity);
        end
    end

    assign w_start = !i_cfg_touch && !r_busy && !r_valid && i_start_ok;
    assign w_done  = r_busy && (r_step == r_act.par - PAR_W'(1));

    always_comb begin
        w_g_next[0] = gf_mul(r_g[0], r_root, r_act.poly);
        for (int i = 1; i < MAX_PARITY; i++) begin
            w_g_next[i] = r_g[i-1] ^ gf_mul(r_g[i], r_root, r_act.poly);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_act   <= '0;
        end else if (i_cfg_touch) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else if (r_busy) begin
            r_step <= r_step + PAR_W'(1);
            if (w_done) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end else if (w_start) begin
            r_busy     <= 1'b1;
            r_step     <= '0;
            r_act.poly <= i_cfg_poly;
            r_act.par  <= w_par_clamped;
        end
    end

    // The product starts as the constant polynomial 1.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_g    <= t_sym_arr'(1);
            r_root <= SYMBOL_BITS'(2);
        end else if (r_busy) begin
            r_g    <= w_g_next;
            r_root <= gf_xtime(r_root, r_act.poly);
        end
    end

    assign o_coeffs        = r_g;
    assign o_act           = r_act;
    assign o_status.valid  = r_valid;
    assign o_status.busy   = r_busy;

endmodule

// File: src/rsse_back.sv
// Encoder back end: division LFSR, echo of each symbol and read-out of parity
// into the output register. Depends on rsse_pkg.
module rsse_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  rsse_pkg::t_qent             i_entry,
    output logic                        o_pop,
    input  rsse_pkg::t_sym_arr          i_coeffs,
    input  rsse_pkg::t_gen_cfg          i_act,
    output logic                        o_idle,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rsse_pkg::DATA_W-1:0] o_data,
    output logic                        o_user,
    output logic                        o_last
);
    import rsse_pkg::*;

    typedef enum logic [1:0] {
        ST_DATA   = 2'b01,
        ST_PARITY = 2'b10
    } t_back_state;

    t_back_state      r_state, n_state;
    t_sym_arr         r_p, n_p;
    logic [PAR_W-1:0] r_left, n_left;
    logic             r_valid, n_valid;
    t_sym             r_sym, n_sym;
    logic             r_isp, n_isp;
    logic             r_eoc, n_eoc;

    t_sym_arr         w_lfsr;
    t_sym_arr         w_shift;
    logic [PAR_W-1:0] w_top;
    t_sym             w_tap;
    t_sym             w_fb;
    logic             w_load;

    assign w_top  = i_act.par - PAR_W'(1);
    assign w_tap  = r_p[w_top[IDX_W-1:0]];
    assign w_fb   = i_entry.sym ^ w_tap;
    assign w_load = !r_valid || i_ready;

    // Stages at or above the parity count are kept at zero.
    always_comb begin
        w_lfsr[0]  = gf_mul(w_fb, i_coeffs[0], i_act.poly);
        w_shift[0] = '0;
        for (int i = 1; i < MAX_PARITY; i++) begin
            if (PAR_W'(i) < i_act.par) begin
                w_lfsr[i]  = r_p[i-1] ^ gf_mul(w_fb, i_coeffs[i], i_act.poly);
                w_shift[i] = r_p[i-1];
            end else begin
                w_lfsr[i]  = '0;
                w_shift[i] = '0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_left  = r_left;
        n_valid = r_valid && !i_ready;
        n_sym   = r_sym;
        n_isp   = r_isp;
        n_eoc   = r_eoc;
        o_pop   = 1'b0;
        case (r_state)
            ST_DATA: begin
                if (i_q_valid && w_load) begin
                    o_pop   = 1'b1;
                    n_valid = 1'b1;
                    n_sym   = i_entry.sym;
                    n_isp   = 1'b0;
                    n_eoc   = 1'b0;
                    n_p     = w_lfsr;
                    if (i_entry.last) begin
                        n_state = ST_PARITY;
                        n_left  = i_act.par;
                    end
                end
            end
            ST_PARITY: begin
                if (w_load) begin
                    n_valid = 1'b1;
                    n_sym   = w_tap;
                    n_isp   = 1'b1;
                    n_eoc   = (r_left == PAR_W'(1));
                    n_p     = w_shift;
                    n_left  = r_left - PAR_W'(1);
                    if (r_left == PAR_W'(1)) begin
                        n_state = ST_DATA;
                    end
                end
            end
            default: begin
                n_state = ST_DATA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DATA;
            r_p     <= '0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_isp <= n_isp;
        r_eoc <= n_eoc;
    end

    assign o_idle  = (r_state == ST_DATA);
    assign o_valid = r_valid;
    assign o_data  = DATA_W'(r_sym);
    assign o_user  = r_isp;
    assign o_last  = r_eoc;

endmodule
